>>> src/asa_pkg.sv
// shared types, codes and constants of the shelf slot allocator
package asa_pkg;

  localparam int DEF_RECYCLE_DEPTH    = 32;
  localparam int DEF_MAX_ATLAS_HEIGHT = 1024;
  localparam int START_HEIGHT         = 128;
  localparam int ATLAS_WIDTH_RST      = 128;
  localparam int PAD2                 = 2;

  localparam int POS_W = 10;
  localparam int SZ_W  = 11;
  localparam int ST_W  = 3;

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  localparam logic [ST_W-1:0] ST_NEW      = 3'd0;
  localparam logic [ST_W-1:0] ST_REUSED   = 3'd1;
  localparam logic [ST_W-1:0] ST_LIMIT    = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [ST_W-1:0] ST_RELEASED = 3'd4;
  localparam logic [ST_W-1:0] ST_DROPPED  = 3'd5;

  typedef struct packed {
    logic [POS_W-1:0] left;
    logic [POS_W-1:0] top;
    logic [SZ_W-1:0]  w;
    logic [SZ_W-1:0]  h;
  } slot_t;

  typedef struct packed {
    logic            accept;
    logic            rel_push;
    logic            rd_first;
    logic            ptr_inc;
    logic            take_hit;
    logic            cmp_write;
    logic            cnt_dec;
    logic            close_shelf;
    logic            grow;
    logic            place;
    logic            set_code;
    logic [ST_W-1:0] code;
    logic            load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_release;
    logic glyph_empty;
    logic release_drop;
    logic list_empty;
    logic hit;
    logic last;
    logic need_close;
    logic over_height;
    logic over_max;
  } dp_stat_t;

endpackage

>>> src/asa_req_if.sv
// request channel of the shelf slot allocator
interface asa_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [9:0]  glyph_width;
  logic [9:0]  glyph_height;
  logic [9:0]  release_left;
  logic [9:0]  release_top;
  logic [10:0] release_w;
  logic [10:0] release_h;

  modport source (
    output valid, req_type, glyph_width, glyph_height,
    output release_left, release_top, release_w, release_h,
    input  ready
  );
  modport sink (
    input  valid, req_type, glyph_width, glyph_height,
    input  release_left, release_top, release_w, release_h,
    output ready
  );
endinterface

>>> src/asa_res_if.sv
// result channel of the shelf slot allocator
interface asa_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [9:0]  slot_left;
  logic [9:0]  slot_top;
  logic [10:0] slot_w;
  logic [10:0] slot_h;
  logic [10:0] atlas_height_now;
  logic        height_grew;

  modport source (
    output valid, status, slot_left, slot_top, slot_w, slot_h,
    output atlas_height_now, height_grew,
    input  ready
  );
  modport sink (
    input  valid, status, slot_left, slot_top, slot_w, slot_h,
    input  atlas_height_now, height_grew,
    output ready
  );
endinterface

>>> src/asa_cfg_if.sv
// configuration write channel of the shelf slot allocator
interface asa_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] atlas_width;

  modport source (
    output valid, atlas_width,
    input  ready
  );
  modport sink (
    input  valid, atlas_width,
    output ready
  );
endinterface

>>> src/atlas_shelf_slot_allocator.sv
// top level of the shelf packing texture atlas slot allocator
// Each request either allocates a padded slot (recycled first fit, else the open shelf,
// doubling the atlas height up to MAX_ATLAS_HEIGHT) or releases a slot onto the recycled
// list of RECYCLE_DEPTH entries. One request is worked at a time and gives one result.
// A release or an empty glyph goes straight to its result. An allocate walks the live
// recycled entries, examining each before a hit and moving each later one down after it;
// on a hit it takes that slot, on a miss it closes the shelf if needed and doubles the
// atlas height as needed. The single read port of the recycled list ram sets the search
// and compaction pace. The result register lets the next request be accepted while a
// result waits. atlas_width must be written by the user only while no request is in
// flight; the block does not enforce it. There is no clearing pass after reset.
module atlas_shelf_slot_allocator #(
  parameter int RECYCLE_DEPTH    = asa_pkg::DEF_RECYCLE_DEPTH,
  parameter int MAX_ATLAS_HEIGHT = asa_pkg::DEF_MAX_ATLAS_HEIGHT
) (
  input  logic       clk,
  input  logic       rst_n,
  asa_req_if.sink    in_req,
  asa_res_if.source  out_res,
  asa_cfg_if.sink    cfg_wr
);
  import asa_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;
  logic      out_valid;

  assign in_req.ready  = in_ready;
  assign out_res.valid = out_valid;
  assign cfg_wr.ready  = 1'b1;

  asa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_res.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  asa_dp #(
    .RECYCLE_DEPTH   (RECYCLE_DEPTH),
    .MAX_ATLAS_HEIGHT(MAX_ATLAS_HEIGHT)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_we              (cfg_wr.valid),
    .cfg_atlas_width     (cfg_wr.atlas_width),
    .in_req_type         (in_req.req_type),
    .in_glyph_width      (in_req.glyph_width),
    .in_glyph_height     (in_req.glyph_height),
    .in_release_left     (in_req.release_left),
    .in_release_top      (in_req.release_top),
    .in_release_w        (in_req.release_w),
    .in_release_h        (in_req.release_h),
    .out_status          (out_res.status),
    .out_slot_left       (out_res.slot_left),
    .out_slot_top        (out_res.slot_top),
    .out_slot_w          (out_res.slot_w),
    .out_slot_h          (out_res.slot_h),
    .out_atlas_height_now(out_res.atlas_height_now),
    .out_height_grew     (out_res.height_grew)
  );
endmodule

>>> src/asa_ram.sv
// generic single write port ram with registered read
module asa_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

>>> src/asa_ctrl.sv
// controller state machine of the shelf slot allocator
module asa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  asa_pkg::dp_stat_t  stat,
  output asa_pkg::ctrl_cmd_t cmd
);
  import asa_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_SEARCH  = 3'd2;
  localparam logic [2:0] S_COMPACT = 3'd3;
  localparam logic [2:0] S_CLOSE   = 3'd4;
  localparam logic [2:0] S_PLACE   = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_release) begin
          cmd.set_code = 1'b1;
          if (stat.release_drop) begin
            cmd.code = ST_DROPPED;
          end else begin
            cmd.code     = ST_RELEASED;
            cmd.rel_push = 1'b1;
          end
          state_nxt = S_DONE;
        end else if (stat.glyph_empty) begin
          cmd.set_code = 1'b1;
          cmd.code     = ST_EMPTY;
          state_nxt    = S_DONE;
        end else if (stat.list_empty) begin
          state_nxt = S_CLOSE;
        end else begin
          cmd.rd_first = 1'b1;
          state_nxt    = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (stat.hit) begin
          cmd.take_hit = 1'b1;
          state_nxt    = S_COMPACT;
        end else if (stat.last) begin
          state_nxt = S_CLOSE;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_COMPACT: begin
        if (stat.last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.cmp_write = 1'b1;
          cmd.ptr_inc   = 1'b1;
        end
      end
      S_CLOSE: begin
        cmd.close_shelf = stat.need_close;
        state_nxt       = S_PLACE;
      end
      S_PLACE: begin
        if (stat.over_height) begin
          if (stat.over_max) begin
            cmd.set_code = 1'b1;
            cmd.code     = ST_LIMIT;
            state_nxt    = S_DONE;
          end else begin
            cmd.grow = 1'b1;
          end
        end else begin
          cmd.place = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
endmodule

>>> src/asa_dp.sv
// datapath of the shelf slot allocator: shelf state, recycled list, result registers
module asa_dp #(
  parameter int RECYCLE_DEPTH    = asa_pkg::DEF_RECYCLE_DEPTH,
  parameter int MAX_ATLAS_HEIGHT = asa_pkg::DEF_MAX_ATLAS_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  asa_pkg::ctrl_cmd_t          cmd,
  output asa_pkg::dp_stat_t           stat,
  input  logic                        cfg_we,
  input  logic [asa_pkg::SZ_W-1:0]    cfg_atlas_width,
  input  logic                        in_req_type,
  input  logic [asa_pkg::POS_W-1:0]   in_glyph_width,
  input  logic [asa_pkg::POS_W-1:0]   in_glyph_height,
  input  logic [asa_pkg::POS_W-1:0]   in_release_left,
  input  logic [asa_pkg::POS_W-1:0]   in_release_top,
  input  logic [asa_pkg::SZ_W-1:0]    in_release_w,
  input  logic [asa_pkg::SZ_W-1:0]    in_release_h,
  output logic [asa_pkg::ST_W-1:0]    out_status,
  output logic [asa_pkg::POS_W-1:0]   out_slot_left,
  output logic [asa_pkg::POS_W-1:0]   out_slot_top,
  output logic [asa_pkg::SZ_W-1:0]    out_slot_w,
  output logic [asa_pkg::SZ_W-1:0]    out_slot_h,
  output logic [asa_pkg::SZ_W-1:0]    out_atlas_height_now,
  output logic                        out_height_grew
);
  import asa_pkg::*;

  localparam int CW  = $clog2(RECYCLE_DEPTH + 1);
  localparam int IW  = (RECYCLE_DEPTH > 1) ? $clog2(RECYCLE_DEPTH) : 1;
  localparam int AHW = $clog2(MAX_ATLAS_HEIGHT) + 2;
  localparam int YW  = (AHW > SZ_W) ? AHW : SZ_W;
  localparam int TW  = YW + 1;

  logic [SZ_W-1:0]  aw_r;
  logic             req_type_r;
  logic [POS_W-1:0] gw_r;
  logic [POS_W-1:0] gh_r;
  logic [POS_W-1:0] rl_r;
  logic [POS_W-1:0] rt_r;
  logic [SZ_W-1:0]  rw_r;
  logic [SZ_W-1:0]  rh_r;

  logic [SZ_W-1:0]  shelf_x_r;
  logic [YW-1:0]    shelf_y_r;
  logic [SZ_W-1:0]  shelf_h_r;
  logic [AHW-1:0]   ah_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    ptr_r;
  logic             grew_r;

  logic [ST_W-1:0]  res_status_r;
  logic [POS_W-1:0] res_left_r;
  logic [POS_W-1:0] res_top_r;
  logic [SZ_W-1:0]  res_w_r;
  logic [SZ_W-1:0]  res_h_r;

  logic [ST_W-1:0]  out_status_r;
  logic [POS_W-1:0] out_left_r;
  logic [POS_W-1:0] out_top_r;
  logic [SZ_W-1:0]  out_w_r;
  logic [SZ_W-1:0]  out_h_r;
  logic [SZ_W-1:0]  out_ah_r;
  logic             out_grew_r;

  logic [SZ_W-1:0]  pw;
  logic [SZ_W-1:0]  ph;
  logic [CW-1:0]    ptr_p1;
  logic [CW-1:0]    ptr_p2;
  logic [SZ_W:0]    x_sum;
  logic [TW-1:0]    target;
  logic [TW-1:0]    shelf_bottom;
  slot_t            rd_slot;
  slot_t            wr_slot;
  logic [$bits(slot_t)-1:0] ram_rdata;
  logic             ram_we;
  logic [IW-1:0]    ram_waddr;
  logic [IW-1:0]    ram_raddr;

  assign pw           = SZ_W'(gw_r) + SZ_W'(PAD2);
  assign ph           = SZ_W'(gh_r) + SZ_W'(PAD2);
  assign ptr_p1       = ptr_r + CW'(1);
  assign ptr_p2       = ptr_r + CW'(2);
  assign x_sum        = {1'b0, shelf_x_r} + {1'b0, pw};
  assign target       = {1'b0, shelf_y_r} + TW'(ph);
  assign shelf_bottom = {1'b0, shelf_y_r} + TW'(shelf_h_r);
  assign rd_slot      = slot_t'(ram_rdata);

  assign stat.is_release   = (req_type_r == REQ_RELEASE);
  assign stat.glyph_empty  = (gw_r == '0) || (gh_r == '0);
  assign stat.release_drop = (rw_r == '0) || (rh_r == '0) || (count_r >= CW'(RECYCLE_DEPTH));
  assign stat.list_empty   = (count_r == '0);
  assign stat.hit          = (rd_slot.w >= pw) && (rd_slot.h >= ph);
  assign stat.last         = (ptr_p1 >= count_r);
  assign stat.need_close   = (x_sum > {1'b0, aw_r});
  assign stat.over_height  = (target > TW'(ah_r));
  assign stat.over_max     = (target > TW'(MAX_ATLAS_HEIGHT));

  // recycled list in insertion order, entries below count_r are live
  always_comb begin
    wr_slot.left = rl_r;
    wr_slot.top  = rt_r;
    wr_slot.w    = rw_r;
    wr_slot.h    = rh_r;
  end

  // while compacting, the entry above the one being written is already in rd_slot
  assign ram_we    = cmd.rel_push | cmd.cmp_write;
  assign ram_waddr = cmd.rel_push ? count_r[IW-1:0] : ptr_r[IW-1:0];
  assign ram_raddr = cmd.rd_first ? '0 :
                     (cmd.cmp_write ? ptr_p2[IW-1:0] : ptr_p1[IW-1:0]);

  asa_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(RECYCLE_DEPTH)
  ) u_recycle_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(cmd.rel_push ? wr_slot : rd_slot),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_r      <= SZ_W'(ATLAS_WIDTH_RST);
      shelf_x_r <= '0;
      shelf_y_r <= '0;
      shelf_h_r <= '0;
      ah_r      <= AHW'(START_HEIGHT);
      count_r   <= '0;
      ptr_r     <= '0;
      grew_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        aw_r <= cfg_atlas_width;
      end
      if (cmd.rel_push) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.rd_first) begin
        ptr_r <= '0;
      end else if (cmd.ptr_inc) begin
        ptr_r <= ptr_p1;
      end
      if (cmd.accept) begin
        grew_r <= 1'b0;
      end else if (cmd.grow) begin
        grew_r <= 1'b1;
      end
      if (cmd.close_shelf) begin
        shelf_y_r <= shelf_y_r + YW'(shelf_h_r);
        shelf_x_r <= '0;
        shelf_h_r <= '0;
      end else if (cmd.place) begin
        shelf_x_r <= shelf_x_r + pw;
        if (ph > shelf_h_r) begin
          shelf_h_r <= ph;
        end
      end
      if (cmd.grow) begin
        ah_r <= ah_r << 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_type_r <= in_req_type;
      gw_r       <= in_glyph_width;
      gh_r       <= in_glyph_height;
      rl_r       <= in_release_left;
      rt_r       <= in_release_top;
      rw_r       <= in_release_w;
      rh_r       <= in_release_h;
    end
    if (cmd.set_code) begin
      res_status_r <= cmd.code;
      res_left_r   <= '0;
      res_top_r    <= '0;
      res_w_r      <= '0;
      res_h_r      <= '0;
    end else if (cmd.take_hit) begin
      res_status_r <= ST_REUSED;
      res_left_r   <= rd_slot.left;
      res_top_r    <= rd_slot.top;
      res_w_r      <= rd_slot.w;
      res_h_r      <= rd_slot.h;
    end else if (cmd.place) begin
      res_status_r <= ST_NEW;
      res_left_r   <= shelf_x_r[POS_W-1:0];
      res_top_r    <= shelf_y_r[POS_W-1:0];
      res_w_r      <= pw;
      res_h_r      <= ph;
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_left_r   <= res_left_r;
      out_top_r    <= res_top_r;
      out_w_r      <= res_w_r;
      out_h_r      <= res_h_r;
      out_ah_r     <= SZ_W'(ah_r);
      out_grew_r   <= grew_r;
    end
  end

  assign out_status           = out_status_r;
  assign out_slot_left        = out_left_r;
  assign out_slot_top         = out_top_r;
  assign out_slot_w           = out_w_r;
  assign out_slot_h           = out_h_r;
  assign out_atlas_height_now = out_ah_r;
  assign out_height_grew      = out_grew_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(RECYCLE_DEPTH))
    else $error("recycled count past list depth");

  a_height_pow2: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(ah_r))
    else $error("atlas height not a power of two");

  a_shelf_fits: assert property (@(posedge clk) disable iff (!rst_n)
    shelf_bottom <= TW'(ah_r))
    else $error("open shelf reaches below atlas height");

  a_grow_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.grow |-> (stat.over_height && !stat.over_max))
    else $error("atlas height doubled without need or past limit");
endmodule
